### rtl/packet_test_window_stats_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef PACKET_TEST_WINDOW_STATS_UNIT_DEFINES_SVH
`define PACKET_TEST_WINDOW_STATS_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PTWS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PTWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/ptws_pkg.sv
// Package of shared types and constants for the test-window statistics unit.
package ptws_pkg;
  localparam logic [31:0] TAG_MAGIC = 32'h64ab83cd;
  localparam logic [15:0] MIN_FRAME = 16'd50;
  localparam logic [1:0] REG_PPT = 2'd0;
  localparam logic [1:0] REG_PROG = 2'd1;
  localparam logic [1:0] REG_HDR = 2'd2;
  localparam int IN_W = 136;
  localparam int OUT_W = 256;

  typedef struct packed {
    logic load;       // latch packet
    logic div_start;  // start a division
    logic sel_next;   // dividend is seq + 1
    logic sel_cnt;    // dividend is the count after this packet, divisor the interval
    logic take_open;  // keep the opening quotient and its comparison
    logic take_close; // keep the closing quotient and its comparison
    logic take_prog;  // keep the progress remainder check
    logic open_chk;   // opening step
    logic close_chk;  // closing step
    logic clear;      // clear test with the kept quotient
    logic count;      // add the packet to the sums
    logic emit_final;
    logic emit_prog;
    logic emit_last;
  } ctl_t;

  typedef struct packed {
    logic div_busy;
    logic drop;
    logic open_ahead;  // opening quotient greater than current test
    logic close_ahead; // closing quotient greater than the test after opening
    logic prog_hit;
    logic out_full;
  } sts_t;
endpackage

### rtl/ptws_div.sv
// Bit-serial unsigned 32-bit divider, one quotient bit per cycle.
module ptws_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  logic [31:0] rem;
  logic [31:0] dvd;
  logic [31:0] dvs;
  logic [5:0] cnt;
  logic [32:0] trial;

  assign trial = {rem, dvd[31]} - {1'b0, dvs};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 6'd32;
      rem <= '0;
      dvd <= dividend;
      dvs <= (divisor == 32'd0) ? 32'd1 : divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], dvd[31]};
        quotient <= {quotient[30:0], 1'b0};
      end
      dvd <= {dvd[30:0], 1'b0};
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
endmodule

### rtl/ptws_ctrl.sv
// Controller state machine that sequences one packet through the datapath.
module ptws_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  ptws_pkg::sts_t sts,
  output logic          in_ready,
  output ptws_pkg::ctl_t ctl
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_OPEN = 3'd3;
  localparam logic [2:0] S_PROG = 3'd4;
  localparam logic [2:0] S_DIV2 = 3'd5;
  localparam logic [2:0] S_CLOSE = 3'd6;
  localparam logic [2:0] S_DIVP = 3'd7;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  // All three divisions run before the first record, so that every record
  // already knows whether it is the last one of its packet.
  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_IDLE: if (in_fire) begin
        ctl.load = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.drop) state_next = S_IDLE;
        else begin
          ctl.div_start = 1'b1;
          state_next = S_DIV1;
        end
      end
      S_DIV1: if (!sts.div_busy) begin
        ctl.take_open = 1'b1;
        ctl.div_start = 1'b1;
        ctl.sel_next = 1'b1;
        state_next = S_DIV2;
      end
      S_DIV2: if (!sts.div_busy) begin
        ctl.take_close = 1'b1;
        ctl.div_start = 1'b1;
        ctl.sel_cnt = 1'b1;
        state_next = S_DIVP;
      end
      S_DIVP: if (!sts.div_busy) begin
        ctl.take_prog = 1'b1;
        state_next = S_OPEN;
      end
      S_OPEN: begin
        if (sts.open_ahead) begin
          if (!sts.out_full) begin
            ctl.emit_final = 1'b1;
            ctl.emit_last = !(sts.prog_hit || sts.close_ahead);
            ctl.clear = 1'b1;
            ctl.count = 1'b1;
            state_next = S_PROG;
          end
        end else begin
          ctl.count = 1'b1;
          state_next = S_PROG;
        end
      end
      S_PROG: begin
        if (sts.prog_hit) begin
          if (!sts.out_full) begin
            ctl.emit_prog = 1'b1;
            ctl.emit_last = !sts.close_ahead;
            state_next = S_CLOSE;
          end
        end else state_next = S_CLOSE;
      end
      S_CLOSE: begin
        if (sts.close_ahead) begin
          if (!sts.out_full) begin
            ctl.emit_final = 1'b1;
            ctl.emit_last = 1'b1;
            ctl.clear = 1'b1;
            state_next = S_IDLE;
          end
        end else state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    ctl.open_chk = (state == S_OPEN);
    ctl.close_chk = (state == S_CLOSE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

### rtl/ptws_dp.sv
// Datapath: test state, sums, timestamps and the output record buffer.
module ptws_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  ptws_pkg::ctl_t             ctl,
  output ptws_pkg::sts_t             sts,
  input  logic [ptws_pkg::IN_W-1:0]  in_data,
  input  logic                       cfg_fire,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ptws_pkg::OUT_W-1:0] out_data,
  output logic                       out_user,
  output logic                       out_last
);
  logic [31:0] ppt, prog;
  logic [5:0] hdr;
  logic [15:0] len;
  logic [30:0] seq;
  logic [19:0] usec;
  logic tag_ok;
  logic [30:0] cur;
  logic [31:0] rcnt;
  logic have_first;
  logic [63:0] lsum, psum, fst, lst;
  logic [63:0] stamp;
  logic [31:0] quot;
  logic [31:0] rem;
  logic div_busy;
  logic [31:0] div_a, div_b;
  logic [31:0] cnt_new;
  logic [31:0] q_open, q_close;
  logic open_r, close_r, prog_r;
  logic [63:0] stamp_mul;
  logic [63:0] elapsed;
  logic [30:0] rec_cur;
  logic [31:0] rec_cnt;
  logic [63:0] rec_l, rec_p;
  logic [63:0] c_lsum, c_psum;
  logic [31:0] c_rcnt;
  logic [15:0] pay;

  // Count after this packet, for the progress remainder.
  assign cnt_new = (open_r ? 32'd0 : rcnt) + 32'd1;
  assign div_a = ctl.sel_cnt ? cnt_new :
                 (ctl.sel_next ? ({1'b0, seq} + 32'd1) : {1'b0, seq});
  assign div_b = ctl.sel_cnt ? prog : ppt;

  ptws_div u_div (
    .clk(clk), .rst(rst), .start(ctl.div_start),
    .dividend(div_a), .divisor(div_b), .busy(div_busy), .quotient(quot),
    .remainder(rem)
  );

  assign sts.div_busy = div_busy;
  assign sts.drop = (len < ptws_pkg::MIN_FRAME) || !tag_ok;
  assign sts.open_ahead = open_r;
  assign sts.close_ahead = close_r;
  assign sts.prog_hit = prog_r;
  assign sts.out_full = out_valid;
  assign stamp = stamp_mul + {44'd0, usec};
  assign pay = (len >= {10'd0, hdr}) ? (len - {10'd0, hdr}) : 16'd0;

  // Values after an optional clear in the opening step.
  always_comb begin
    c_rcnt = rcnt;
    c_lsum = lsum;
    c_psum = psum;
    if (ctl.open_chk && ctl.clear) begin
      c_rcnt = '0;
      c_lsum = '0;
      c_psum = '0;
    end
  end

  assign rec_cur = cur;
  assign rec_cnt = rcnt;
  assign rec_l = lsum;
  assign rec_p = psum;
  assign elapsed = (lst >= fst) ? (lst - fst) : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ppt <= 32'd1;
      prog <= 32'd0;
      hdr <= 6'd42;
      cur <= '0;
      rcnt <= '0;
      have_first <= 1'b0;
      lsum <= '0;
      psum <= '0;
      fst <= '0;
      lst <= '0;
      out_valid <= 1'b0;
      open_r <= 1'b0;
      close_r <= 1'b0;
      prog_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          ptws_pkg::REG_PPT: ppt <= cfg_data;
          ptws_pkg::REG_PROG: prog <= cfg_data;
          ptws_pkg::REG_HDR: hdr <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (ctl.load) begin
        len <= in_data[15:0];
        tag_ok <= in_data[47:16] == ptws_pkg::TAG_MAGIC;
        seq <= in_data[78:48];
        usec <= in_data[130:111];
        stamp_mul <= {32'd0, in_data[110:79]} * 64'd1000000;
      end
      if (ctl.take_open) begin
        q_open <= quot;
        open_r <= quot > {1'b0, cur};
      end
      if (ctl.take_close) begin
        q_close <= quot;
        close_r <= quot > (open_r ? {1'b0, q_open[30:0]} : {1'b0, cur});
      end
      if (ctl.take_prog) prog_r <= (prog != 32'd0) && (rem == 32'd0);
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (ctl.emit_final || ctl.emit_prog) begin
        out_valid <= 1'b1;
        out_data <= {1'b0, elapsed, rec_p, rec_l, rec_cnt, rec_cur};
        out_user <= ctl.emit_final;
        out_last <= ctl.emit_last;
      end
      if (ctl.count) begin
        lsum <= c_lsum + {48'd0, len};
        psum <= c_psum + {48'd0, pay};
        rcnt <= c_rcnt + 32'd1;
        if (!have_first || (ctl.clear)) fst <= stamp;
        have_first <= 1'b1;
        lst <= stamp;
        if (ctl.clear) cur <= q_open[30:0];
      end
      if (ctl.close_chk && ctl.clear) begin
        cur <= q_close[30:0];
        rcnt <= '0;
        lsum <= '0;
        psum <= '0;
        have_first <= 1'b0;
      end
    end
  end
endmodule

### rtl/packet_test_window_stats_unit.sv
// Top level of the packet test-window statistics unit.
// Each input transfer is checked, then runs through three serial divisions before the
//   opening, progress and closing steps, each of which may write one record.
// A new packet is accepted only once the last one has finished or been dropped, and
//   a full output stalls the steps. Records wait in a single output register.
// Reset is synchronous and active high; it restores register defaults and clears test state.
module packet_test_window_stats_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // frame_length, tag_word, sequence_number, stamp_seconds, stamp_micros, zero fill
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // test_index, packet_count, byte_total, payload_total, elapsed_micros, zero fill
  output logic [255:0] m_tdata,
  // is_final
  output logic         m_tuser,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  ptws_pkg::ctl_t ctl;
  ptws_pkg::sts_t sts;

  // Configuration is always accepted; the user must write only while the unit is idle, as the unit does not enforce it.
  assign cfg_ready = 1'b1;

  ptws_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(s_tvalid && s_tready),
    .sts(sts), .in_ready(s_tready), .ctl(ctl)
  );

  ptws_dp u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .in_data(s_tdata),
    .cfg_fire(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata), .out_user(m_tuser),
    .out_last(m_tlast)
  );
endmodule

### rtl/ptws_checker.sv
// Port-level checker for the statistics unit and its bind.
`include "packet_test_window_stats_unit_defines.svh"
module ptws_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic m_tuser,
  input logic m_tlast,
  input logic [255:0] m_tdata
);
  `PTWS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}))
  `PTWS_ASSERT_NEXT(a_busy_after_in, clk, rst, s_tvalid && s_tready, !s_tready)
  `PTWS_ASSERT_IMP(a_pad_zero, clk, rst, m_tvalid, m_tdata[255] == 1'b0)
endmodule

bind packet_test_window_stats_unit ptws_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tlast(m_tlast),
  .m_tdata(m_tdata)
);
